[sv/box_blur_3x3_edge_average_macros.svh]
// assertion macros for the 3x3 box blur checker
`ifndef BOX_BLUR_3X3_EDGE_AVERAGE_MACROS_SVH
`define BOX_BLUR_3X3_EDGE_AVERAGE_MACROS_SVH

// checked only outside reset
`define BB3_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("bb3 port check failed");

// checked on every edge, reset included
`define BB3_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("bb3 port check failed");

`endif

[sv/bb3_pkg.sv]
// shared constants, types and tables of the 3x3 box blur
package bb3_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int SIZE_W   = 11;
   localparam int COL_W    = $clog2(MAX_WIDTH);
   localparam int OROW_W   = $clog2(MAX_HEIGHT);
   localparam int IROW_W   = $clog2(MAX_HEIGHT + 2);
   localparam int PIX_W    = 24;
   localparam int CH_W     = 8;
   localparam int NUM_CH   = 3;
   localparam int SUM_W    = 12;
   localparam int NUM_W    = 13;
   localparam int CNT_W    = 4;
   localparam int DIV_W    = CNT_W + 1;
   localparam int RECIP_W  = 16;
   localparam int PROD_W   = NUM_W + RECIP_W;
   localparam int QD_W     = CH_W + DIV_W;

   localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   typedef struct packed {
      logic accept;
      logic step;
      logic mul;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic skip;
      logic emit;
      logic out_free;
   } status_type;

   // floor(2^16 / (2*count)) for the neighbor counts that can occur
   function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
      logic [RECIP_W-1:0] r;
      case (cnt)
         4'd1:    r = 16'd32768;
         4'd2:    r = 16'd16384;
         4'd3:    r = 16'd10922;
         4'd4:    r = 16'd8192;
         4'd5:    r = 16'd6553;
         4'd6:    r = 16'd5461;
         4'd7:    r = 16'd4681;
         4'd8:    r = 16'd4096;
         4'd9:    r = 16'd3640;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

[sv/box_blur_3x3_edge_average.sv]
// top level of the 3x3 edge-aware box blur
//
//  channel  direction  handshake               word
//  req      in         req_valid / req_ready   req_operation, req_pixel
//  rsp      out        rsp_valid / rsp_ready   rsp_blurred_pixel, rsp_frame_end
//  csr      in         csr_write_enable        csr_index, csr_write_data
//
// a word that gives a result passes accept, line store update and sums, reciprocal
// multiply and correction, a word without result ends after the sums, an ignored flush
// after accept; the single-port line store read-then-write sets this
// the output register holds a result while the next word is taken
// a stalled rsp holds the controller in its last step until the register frees
// reset is synchronous; the line store is not cleared and needs no clearing pass
module box_blur_3x3_edge_average (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_operation,
   input  logic [bb3_pkg::PIX_W-1:0]  req_pixel,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [bb3_pkg::PIX_W-1:0]  rsp_blurred_pixel,
   output logic                       rsp_frame_end,
   input  logic                       csr_write_enable,
   input  logic                       csr_index,
   input  logic [bb3_pkg::SIZE_W-1:0] csr_write_data
);
   import bb3_pkg::*;

   cmd_type    cmd;
   status_type status;

   bb3_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bb3_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_operation     (req_operation),
      .req_pixel         (req_pixel),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_blurred_pixel (rsp_blurred_pixel),
      .rsp_frame_end     (rsp_frame_end),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

endmodule

[sv/bb3_ctrl.sv]
// controller state machine of the 3x3 box blur
module bb3_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  bb3_pkg::status_type status,
   output bb3_pkg::cmd_type    cmd
);
   import bb3_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SUM  = 2'd1;
   localparam logic [1:0] ST_MUL  = 2'd2;
   localparam logic [1:0] ST_FIX  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (!status.skip) begin
                  state_in = ST_SUM;
               end
            end
         end
         ST_SUM: begin
            cmd.step = 1'b1;
            state_in = status.emit ? ST_MUL : ST_IDLE;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_FIX;
         end
         ST_FIX: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

[sv/bb3_datapath.sv]
// line store, window, counters, averaging and output register of the 3x3 box blur
module bb3_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  bb3_pkg::cmd_type              cmd,
   output bb3_pkg::status_type           status,
   input  logic                          req_operation,
   input  logic [bb3_pkg::PIX_W-1:0]     req_pixel,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [bb3_pkg::PIX_W-1:0]     rsp_blurred_pixel,
   output logic                          rsp_frame_end,
   input  logic                          csr_write_enable,
   input  logic                          csr_index,
   input  logic [bb3_pkg::SIZE_W-1:0]    csr_write_data
);
   import bb3_pkg::*;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] maxv);
      logic [SIZE_W-1:0] r;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (v > maxv) begin
         r = maxv;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // sizes and raster counters
   logic [SIZE_W-1:0] width_ff, height_ff;
   logic [COL_W-1:0]  in_col_ff, out_col_ff;
   logic [IROW_W-1:0] in_row_ff;
   logic [OROW_W-1:0] out_row_ff;

   // line store: upper row in the high half, middle row in the low half
   logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
   logic [2*PIX_W-1:0] rd_ff;
   logic [PIX_W-1:0]   pix_ff;

   // window columns left of the incoming one; index 0 top, 2 bottom
   logic [PIX_W-1:0] win_left_ff [3];
   logic [PIX_W-1:0] win_ctr_ff  [3];
   logic [PIX_W-1:0] incoming    [3];

   logic [SUM_W-1:0] sum_in [NUM_CH];
   logic [SUM_W-1:0] sum_ff [NUM_CH];
   logic [CNT_W-1:0] cnt_in, cnt_ff;
   logic             fe_ff;

   logic [NUM_W-1:0] num_ff [NUM_CH];
   logic [CH_W-1:0]  q0_ff  [NUM_CH];
   logic [PROD_W-1:0] prod  [NUM_CH];
   logic [NUM_W-1:0] num    [NUM_CH];
   logic [CH_W-1:0]  q_fix  [NUM_CH];
   logic [QD_W-1:0]  qd     [NUM_CH];
   logic [NUM_W-1:0] rem    [NUM_CH];
   logic [DIV_W-1:0] divisor;

   logic             rsp_valid_ff;
   logic [PIX_W-1:0] rsp_pixel_ff;
   logic             rsp_fe_ff;

   logic             draining, emit, frame_end;
   logic             top_ok, bot_ok, left_ok, right_ok;
   logic [2:0]       row_ok, col_ok;
   logic [PIX_W-1:0] elem;
   logic [SIZE_W-1:0] in_col_p1, out_col_p1, out_row_p1;

   assign draining   = (SIZE_W'(in_row_ff) >= height_ff);
   assign emit       = (in_row_ff >= IROW_W'(2)) ||
                       ((in_row_ff == IROW_W'(1)) && (in_col_ff != '0));
   assign in_col_p1  = SIZE_W'(in_col_ff) + SIZE_W'(1);
   assign out_col_p1 = SIZE_W'(out_col_ff) + SIZE_W'(1);
   assign out_row_p1 = SIZE_W'(out_row_ff) + SIZE_W'(1);
   assign frame_end  = (out_row_p1 >= height_ff) && (out_col_p1 >= width_ff);

   assign top_ok   = (out_row_ff != '0);
   assign bot_ok   = (out_row_p1 < height_ff);
   assign left_ok  = (out_col_ff != '0);
   assign right_ok = (out_col_p1 < width_ff);
   assign row_ok   = {bot_ok, 1'b1, top_ok};
   assign col_ok   = {right_ok, 1'b1, left_ok};

   assign incoming[0] = rd_ff[2*PIX_W-1:PIX_W];
   assign incoming[1] = rd_ff[PIX_W-1:0];
   assign incoming[2] = pix_ff;

   assign status.skip     = !draining && (req_operation == OP_FLUSH);
   assign status.emit     = emit;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // masked neighborhood sums
   always_comb begin
      cnt_in = '0;
      elem   = '0;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         sum_in[ch] = '0;
      end
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            if (row_ok[r] && col_ok[k]) begin
               case (k)
                  0:       elem = win_left_ff[r];
                  1:       elem = win_ctr_ff[r];
                  default: elem = incoming[r];
               endcase
               cnt_in = cnt_in + CNT_W'(1);
               for (int ch = 0; ch < NUM_CH; ch++) begin
                  sum_in[ch] = sum_in[ch] +
                               SUM_W'(elem[PIX_W-CH_W*(ch+1) +: CH_W]);
               end
            end
         end
      end
   end

   // rounded mean: reciprocal estimate, then one correction step
   assign divisor = {cnt_ff, 1'b0};

   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         num[ch]   = NUM_W'({sum_ff[ch], 1'b0}) + NUM_W'(cnt_ff);
         prod[ch]  = PROD_W'(num[ch]) * PROD_W'(recip(cnt_ff));
         qd[ch]    = QD_W'(q0_ff[ch]) * QD_W'(divisor);
         rem[ch]   = num_ff[ch] - NUM_W'(qd[ch]);
         q_fix[ch] = (rem[ch] >= NUM_W'(divisor)) ? q0_ff[ch] + CH_W'(1) : q0_ff[ch];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rd_ff  <= line_mem[in_col_ff];
         pix_ff <= draining ? '0 : req_pixel;
      end
      if (cmd.step) begin
         line_mem[in_col_ff] <= {rd_ff[PIX_W-1:0], pix_ff};
         for (int r = 0; r < 3; r++) begin
            win_left_ff[r] <= win_ctr_ff[r];
            win_ctr_ff[r]  <= incoming[r];
         end
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
         fe_ff  <= frame_end;
      end
      if (cmd.mul) begin
         for (int ch = 0; ch < NUM_CH; ch++) begin
            num_ff[ch] <= num[ch];
            q0_ff[ch]  <= prod[ch][RECIP_W +: CH_W];
         end
      end
      if (cmd.load) begin
         rsp_pixel_ff <= {q_fix[0], q_fix[1], q_fix[2]};
         rsp_fe_ff    <= fe_ff;
      end
   end

   // sizes and raster counters
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WIDTH_RESET;
         height_ff  <= HEIGHT_RESET;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= clamp_size(csr_write_data, SIZE_W'(MAX_WIDTH));
            CSR_IMAGE_HEIGHT: height_ff <= clamp_size(csr_write_data, SIZE_W'(MAX_HEIGHT));
            default: ;
         endcase
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (cmd.step) begin
         if (emit && frame_end) begin
            in_col_ff  <= '0;
            in_row_ff  <= '0;
            out_col_ff <= '0;
            out_row_ff <= '0;
         end else begin
            if (in_col_p1 >= width_ff) begin
               in_col_ff <= '0;
               in_row_ff <= in_row_ff + IROW_W'(1);
            end else begin
               in_col_ff <= in_col_p1[COL_W-1:0];
            end
            if (emit) begin
               if (out_col_p1 >= width_ff) begin
                  out_col_ff <= '0;
                  out_row_ff <= out_row_ff + OROW_W'(1);
               end else begin
                  out_col_ff <= out_col_p1[COL_W-1:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_blurred_pixel = rsp_pixel_ff;
   assign rsp_frame_end     = rsp_fe_ff;

endmodule

[sv/bb3_checker.sv]
// port checks of the 3x3 box blur and their binding to the top level
`include "box_blur_3x3_edge_average_macros.svh"

module bb3_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      req_operation,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [bb3_pkg::PIX_W-1:0] rsp_blurred_pixel,
   input logic                      rsp_frame_end
);
   import bb3_pkg::*;

   logic           req_take;
   logic           rsp_stall;
   logic [PIX_W:0] rsp_word;

   assign req_take  = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_word  = {rsp_blurred_pixel, rsp_frame_end};

   // no result word survives reset
   `BB3_ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_valid)

   // a taken pixel word always moves the block out of idle, so req_ready falls
   `BB3_ASSERT(a_pixel_busy, (req_take && req_operation == OP_PIXEL) |=> !req_ready)

   // a result never rises directly after an accepted word: the sum and multiply steps lie between
   `BB3_ASSERT(a_result_latency, $rose(rsp_valid) |-> (!$past(req_take) && !$past(req_take, 2)))

   // a stalled result holds its word
   `BB3_ASSERT(a_rsp_hold, rsp_stall |=> (rsp_valid && $stable(rsp_word)))

endmodule

bind box_blur_3x3_edge_average bb3_checker u_bb3_checker (.*);

[tb/testbench.sv]
// self-checking testbench for the 3x3 edge-average box blur, with a line-store predictor
`timescale 1ns / 1ps

module testbench;
   import bb3_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic             operation;
      logic [PIX_W-1:0] pixel;
   } stream_word_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             frame_end;
   } blur_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_operation = OP_PIXEL;
   logic [PIX_W-1:0] req_pixel = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [PIX_W-1:0] rsp_blurred_pixel;
   logic rsp_frame_end;
   logic csr_write_enable = 1'b0;
   logic csr_index = CSR_IMAGE_WIDTH;
   logic [SIZE_W-1:0] csr_write_data = '0;

   stream_word_type pixel_words[$];
   blur_result_type awaited_pixels[$];
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   int unsigned stim_count = 0;
   bit idle_enable = 1'b1;
   bit hold_request = 1'b0;
   bit hold_taken = 1'b0;
   int unsigned hold_left = 0;

   // predictor state
   logic [PIX_W-1:0] upper_line [MAX_WIDTH];
   logic [PIX_W-1:0] middle_line [MAX_WIDTH];
   logic [PIX_W-1:0] win_pix [9];
   int unsigned in_col, in_row, out_col, out_row;
   int unsigned frame_width, frame_height;

   box_blur_3x3_edge_average uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_pixel         (req_pixel),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_blurred_pixel (rsp_blurred_pixel),
      .rsp_frame_end     (rsp_frame_end),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always #4 clock = ~clock;

   function automatic int unsigned clamp_size(logic [SIZE_W-1:0] value, int unsigned limit);
      if (value == 0) return 1;
      if (32'(value) > limit) return limit;
      return 32'(value);
   endfunction

   function automatic void restart_frame();
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      for (int n = 0; n < 9; n++) win_pix[n] = '0;
   endfunction

   function automatic void apply_size(logic idx, logic [SIZE_W-1:0] value);
      if (idx == CSR_IMAGE_WIDTH) begin
         frame_width = clamp_size(value, MAX_WIDTH);
      end else begin
         frame_height = clamp_size(value, MAX_HEIGHT);
      end
      restart_frame();
   endfunction

   // mean over the valid neighbors around window column cc
   function automatic logic [PIX_W-1:0] window_average(int unsigned cc);
      int unsigned tot [3];
      int unsigned n_valid, wc, m;
      int r, k, ch;
      bit row_ok, col_ok;
      logic [PIX_W-1:0] p, mean;
      tot = '{0, 0, 0};
      n_valid = 0;
      mean = '0;
      for (r = 0; r < 3; r++) begin
         row_ok = (r == 1) || (r == 0 && out_row >= 1) ||
                  (r == 2 && out_row + 1 < frame_height);
         if (!row_ok) continue;
         for (k = 0; k < 3; k++) begin
            wc = cc + k;
            if (wc < 1 || wc > 3) continue;
            wc = wc - 1;
            col_ok = (k == 1) || (k == 0 && out_col >= 1) ||
                     (k == 2 && out_col + 1 < frame_width);
            if (!col_ok) continue;
            p = win_pix[r * 3 + wc];
            tot[0] += 32'(p[23:16]);
            tot[1] += 32'(p[15:8]);
            tot[2] += 32'(p[7:0]);
            n_valid++;
         end
      end
      if (n_valid == 0) return '0;
      for (ch = 0; ch < 3; ch++) begin
         m = (2 * tot[ch] + n_valid) / (2 * n_valid);
         mean[16 - 8 * ch +: 8] = m[7:0];
      end
      return mean;
   endfunction

   function automatic bit advance_slot(logic [PIX_W-1:0] pix, output logic [PIX_W-1:0] res,
                                       output logic fe);
      int unsigned c;
      bit emit;
      logic [PIX_W-1:0] column [3];
      c = in_col;
      emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      res = '0;
      fe = 1'b0;
      if (emit && c == 0) res = window_average(2);
      if (c < MAX_WIDTH) begin
         column[0] = upper_line[c];
         column[1] = middle_line[c];
         upper_line[c] = middle_line[c];
         middle_line[c] = pix;
      end else begin
         column[0] = '0;
         column[1] = '0;
      end
      column[2] = pix;
      for (int r = 0; r < 3; r++) begin
         win_pix[r * 3] = win_pix[r * 3 + 1];
         win_pix[r * 3 + 1] = win_pix[r * 3 + 2];
         win_pix[r * 3 + 2] = column[r];
      end
      if (emit && c != 0) res = window_average(1);
      in_col++;
      if (in_col >= frame_width) begin
         in_col = 0;
         in_row++;
      end
      if (!emit) return 1'b0;
      fe = (out_row + 1 >= frame_height) && (out_col + 1 >= frame_width);
      if (fe) begin
         restart_frame();
      end else begin
         out_col++;
         if (out_col >= frame_width) begin
            out_col = 0;
            out_row++;
         end
      end
      return 1'b1;
   endfunction

   function automatic bit blur_word(logic op, logic [PIX_W-1:0] pix,
                                    output logic [PIX_W-1:0] res, output logic fe);
      res = '0;
      fe = 1'b0;
      if (in_row >= frame_height) return advance_slot('0, res, fe);
      if (op == OP_PIXEL) return advance_slot(pix, res, fe);
      return 1'b0;
   endfunction

   function automatic logic [PIX_W-1:0] pick_color();
      logic [PIX_W-1:0] v;
      v = PIX_W'($urandom);
      if ($urandom_range(3) == 0) begin
         for (int ch = 0; ch < 3; ch++) v[8 * ch +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
      end
      return v;
   endfunction

   task automatic queue_word(logic op, logic [PIX_W-1:0] pix);
      stream_word_type w;
      w.operation = op;
      w.pixel = pix;
      pixel_words.push_back(w);
   endtask

   task automatic settle();
      while (pixel_words.size() != 0 || req_valid || awaited_pixels.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_size(logic idx, logic [SIZE_W-1:0] value);
      settle();
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      apply_size(idx, value);
   endtask

   // a frame of pixels with stray flushes, then the drain; a broken frame stops early
   task automatic send_frame(int unsigned w, int unsigned h, bit broken);
      int unsigned total, cut, i;
      total = w * h;
      cut = broken ? $urandom_range(total - 1, 0) : total;
      for (i = 0; i < cut; i++) begin
         if ($urandom_range(19) == 0) queue_word(OP_FLUSH, pick_color());
         queue_word(OP_PIXEL, pick_color());
      end
      stim_count += cut;
      if (!broken) begin
         for (i = 0; i <= w; i++)
            queue_word($urandom_range(3) == 0 ? OP_PIXEL : OP_FLUSH, pick_color());
         stim_count += w + 1;
      end
   endtask

   always @(posedge clock) begin : drive_words
      stream_word_type next_word;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pixel_words.size() != 0 && !(idle_enable && $urandom_range(99) < 23)) begin
            next_word = pixel_words.pop_front();
            req_valid <= 1'b1;
            req_operation <= next_word.operation;
            req_pixel <= next_word.pixel;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (hold_request && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left = 400;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(idle_enable && $urandom_range(99) < 23);
      end
   end

   always @(posedge clock) begin : check_words
      logic [PIX_W-1:0] pred_pixel;
      logic pred_end;
      blur_result_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (blur_word(req_operation, req_pixel, pred_pixel, pred_end)) begin
               want.pixel = pred_pixel;
               want.frame_end = pred_end;
               awaited_pixels.push_back(want);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_pixels.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual pixel %h frame_end %b",
                        $time, rsp_blurred_pixel, rsp_frame_end);
               mismatches++;
            end else begin
               want = awaited_pixels.pop_front();
               if (rsp_blurred_pixel !== want.pixel) begin
                  $display("%0t: blurred_pixel expected %h actual %h",
                           $time, want.pixel, rsp_blurred_pixel);
                  mismatches++;
               end
               if (rsp_frame_end !== want.frame_end) begin
                  $display("%0t: frame_end expected %b actual %b",
                           $time, want.frame_end, rsp_frame_end);
                  mismatches++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int unsigned w_raw, h_raw, sel, frames, phase, f;
      logic [PIX_W-1:0] mix [9];
      int i;
      mix = '{24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000, 24'hFF00FF,
              24'h00FF00, 24'h010101, 24'hFEFEFE, 24'h808080};
      for (i = 0; i < MAX_WIDTH; i++) begin
         upper_line[i] = '0;
         middle_line[i] = '0;
      end
      frame_width = clamp_size(WIDTH_RESET, MAX_WIDTH);
      frame_height = clamp_size(HEIGHT_RESET, MAX_HEIGHT);
      restart_frame();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // widest frame, two rows, with a long receiver hold-off
      write_size(CSR_IMAGE_WIDTH, '1);
      write_size(CSR_IMAGE_HEIGHT, SIZE_W'(2));
      send_frame(frame_width, frame_height, 1'b0);
      hold_request = 1'b1;

      // single pixel frames, zero sizes taken as one
      write_size(CSR_IMAGE_WIDTH, '0);
      write_size(CSR_IMAGE_HEIGHT, '0);
      queue_word(OP_FLUSH, 24'hFFFFFF);
      queue_word(OP_PIXEL, 24'hFFFFFF);
      queue_word(OP_PIXEL, 24'h123456);
      queue_word(OP_FLUSH, 24'h000000);
      queue_word(OP_PIXEL, 24'h000000);
      queue_word(OP_FLUSH, 24'hFFFFFF);
      queue_word(OP_FLUSH, 24'h000000);

      // 3x3 with rounding ties, a stray flush and a mixed drain
      write_size(CSR_IMAGE_WIDTH, SIZE_W'(3));
      write_size(CSR_IMAGE_HEIGHT, SIZE_W'(3));
      for (i = 0; i < 9; i++) begin
         queue_word(OP_PIXEL, mix[i]);
         if (i == 3) queue_word(OP_FLUSH, 24'hAAAAAA);
      end
      queue_word(OP_PIXEL, 24'h555555);
      queue_word(OP_FLUSH, 24'h000000);
      queue_word(OP_PIXEL, 24'hFFFFFF);
      queue_word(OP_FLUSH, 24'h000000);

      // one row high
      write_size(CSR_IMAGE_WIDTH, SIZE_W'(2));
      write_size(CSR_IMAGE_HEIGHT, SIZE_W'(1));
      queue_word(OP_PIXEL, 24'hFF0000);
      queue_word(OP_PIXEL, 24'h0000FF);
      for (i = 0; i < 3; i++) queue_word(OP_FLUSH, 24'h000000);

      // tallest frame, one column, no idling
      write_size(CSR_IMAGE_WIDTH, SIZE_W'(1));
      write_size(CSR_IMAGE_HEIGHT, '1);
      settle();
      idle_enable = 1'b0;
      send_frame(frame_width, frame_height, 1'b0);
      settle();
      idle_enable = 1'b1;

      stim_count = 0;
      phase = 0;
      while (stim_count < 1500) begin
         sel = $urandom_range(99);
         if (sel < 3) begin
            w_raw = $urandom_range(2047, 1025);
            h_raw = $urandom_range(1, 0);
         end else begin
            if (sel < 10) w_raw = 0;
            else if (sel < 20) w_raw = $urandom_range(40, 13);
            else w_raw = $urandom_range(12, 1);
            h_raw = ($urandom_range(9) == 0) ? 0 : $urandom_range(12, 1);
         end
         if ($urandom_range(1)) begin
            write_size(CSR_IMAGE_WIDTH, SIZE_W'(w_raw));
            write_size(CSR_IMAGE_HEIGHT, SIZE_W'(h_raw));
         end else begin
            write_size(CSR_IMAGE_HEIGHT, SIZE_W'(h_raw));
            write_size(CSR_IMAGE_WIDTH, SIZE_W'(w_raw));
         end
         idle_enable = !(phase >= 8 && phase < 12);
         if ($urandom_range(9) == 0) begin
            for (i = 0; i < 30; i++) queue_word(1'($urandom_range(1)), pick_color());
            stim_count += 30;
         end else begin
            frames = $urandom_range(3, 1);
            for (f = 0; f < frames; f++) begin
               if ($urandom_range(9) == 0) begin
                  send_frame(frame_width, frame_height, 1'b1);
                  break;
               end
               send_frame(frame_width, frame_height, 1'b0);
            end
         end
         settle();
         phase++;
      end

      idle_enable = 1'b1;
      settle();
      repeat (16) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
